[rtl/jet_pkg.sv]
package jet_pkg;

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
    } t_pix_in;

    typedef struct packed {
        logic [9:0]  out_x;
        logic [9:0]  out_y;
        logic [15:0] iterations;
        logic [1:0]  band;
    } t_pix_out;

    typedef struct packed {
        logic signed [31:0] c_re;
        logic signed [31:0] c_im;
        logic [15:0]        iteration_limit;
        logic signed [31:0] origin_re;
        logic signed [31:0] origin_im;
        logic [30:0]        step_re;
        logic [30:0]        step_im;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_XMUL,
        S_XSUM,
        S_YSUM,
        S_TEST,
        S_IISQ,
        S_ESC,
        S_UPD,
        S_DONE
    } t_state;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_C_RE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C_IM      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_RE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_IM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_IM   = 3'd6;

    localparam logic [1:0] BAND_INSIDE = 2'd0;
    localparam logic [1:0] BAND_LOW    = 2'd1;
    localparam logic [1:0] BAND_MID    = 2'd2;
    localparam logic [1:0] BAND_HIGH   = 2'd3;

    localparam logic [15:0] BAND_LOW_LIM = 16'd33;
    localparam logic [15:0] BAND_MID_LIM = 16'd66;

    // wide intermediate sums before saturation to Q4.28
    localparam int SUM_W = 48;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic fits;
        fits = (v[SUM_W-1:31] == '0) || (v[SUM_W-1:31] == '1);
        if (fits) begin
            return v[31:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, 31'd0};
        end else begin
            return {1'b0, {31{1'b1}}};
        end
    endfunction

endpackage

[rtl/jet_mul.sv]
module jet_mul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [63:0] o_p
);

    logic signed [63:0] r_p;
    logic signed [63:0] n_p;

    assign n_p = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;

endmodule

[rtl/jet_seq.sv]
module jet_seq #(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  jet_pkg::t_cfg    i_cfg,
    input  logic             i_start,
    input  jet_pkg::t_pix_in i_pix,
    input  logic             i_take,
    output logic             o_idle,
    output logic             o_done,
    output jet_pkg::t_pix_out o_res
);

    localparam logic [12:0] FW = 13'(FRAME_WIDTH);
    localparam logic [12:0] FH = 13'(FRAME_HEIGHT);
    localparam int SW = jet_pkg::SUM_W;

    jet_pkg::t_state r_state, n_state;

    logic [9:0]         r_px, r_py;
    logic [15:0]        r_n;
    logic signed [31:0] r_zr, r_zi;
    logic signed [63:0] r_rr;

    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;

    logic [9:0]         px_c, py_c;
    logic signed [SW-1:0] x_sum, y_sum, re_sum, im_sum;
    logic signed [63:0] diff_sh, ri_sh;
    logic [63:0]        mag_sum;
    logic               escaped;

    jet_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    assign px_c = ({3'd0, i_pix.pixel_x} >= FW) ? 10'(FRAME_WIDTH - 1) : i_pix.pixel_x;
    assign py_c = ({3'd0, i_pix.pixel_y} >= FH) ? 10'(FRAME_HEIGHT - 1) : i_pix.pixel_y;

    // start point: origin +/- pixel * step, product is non-negative and below 2^44
    assign x_sum = SW'(i_cfg.origin_re) + prod[SW-1:0];
    assign y_sum = SW'(i_cfg.origin_im) - prod[SW-1:0];

    // r_rr holds rr - ii in S_UPD; arithmetic shift floors toward minus infinity
    assign diff_sh = r_rr >>> 28;
    assign ri_sh   = prod >>> 27;
    assign re_sum  = diff_sh[SW-1:0] + SW'(i_cfg.c_re);
    assign im_sum  = ri_sh[SW-1:0] + SW'(i_cfg.c_im);

    // both squares are non-negative and at most 2^62, so no carry out
    assign mag_sum = 64'(r_rr) + 64'(prod);
    assign escaped = |mag_sum[63:58];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jet_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        mul_a   = r_zr;
        mul_b   = r_zi;
        unique case (r_state)
            jet_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = jet_pkg::S_XMUL;
                end
            end
            jet_pkg::S_XMUL: begin
                mul_a   = signed'({22'd0, r_px});
                mul_b   = signed'({1'b0, i_cfg.step_re});
                n_state = jet_pkg::S_XSUM;
            end
            jet_pkg::S_XSUM: begin
                mul_a   = signed'({22'd0, r_py});
                mul_b   = signed'({1'b0, i_cfg.step_im});
                n_state = jet_pkg::S_YSUM;
            end
            jet_pkg::S_YSUM: begin
                n_state = jet_pkg::S_TEST;
            end
            jet_pkg::S_TEST: begin
                mul_a = r_zr;
                mul_b = r_zr;
                if (r_n == i_cfg.iteration_limit) begin
                    n_state = jet_pkg::S_DONE;
                end else begin
                    n_state = jet_pkg::S_IISQ;
                end
            end
            jet_pkg::S_IISQ: begin
                mul_a   = r_zi;
                mul_b   = r_zi;
                n_state = jet_pkg::S_ESC;
            end
            jet_pkg::S_ESC: begin
                mul_a = r_zr;
                mul_b = r_zi;
                if (escaped) begin
                    n_state = jet_pkg::S_DONE;
                end else begin
                    n_state = jet_pkg::S_UPD;
                end
            end
            jet_pkg::S_UPD: begin
                n_state = jet_pkg::S_TEST;
            end
            jet_pkg::S_DONE: begin
                if (i_take) begin
                    n_state = jet_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = jet_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            jet_pkg::S_IDLE: begin
                r_px <= px_c;
                r_py <= py_c;
                r_n  <= '0;
            end
            jet_pkg::S_XSUM: r_zr <= jet_pkg::sat32(x_sum);
            jet_pkg::S_YSUM: r_zi <= jet_pkg::sat32(y_sum);
            jet_pkg::S_IISQ: r_rr <= prod;
            jet_pkg::S_ESC:  r_rr <= r_rr - prod;
            jet_pkg::S_UPD: begin
                r_zr <= jet_pkg::sat32(re_sum);
                r_zi <= jet_pkg::sat32(im_sum);
                r_n  <= r_n + 16'd1;
            end
            default: ;
        endcase
    end

    assign o_idle = (r_state == jet_pkg::S_IDLE);
    assign o_done = (r_state == jet_pkg::S_DONE);

    always_comb begin
        o_res.out_x      = r_px;
        o_res.out_y      = r_py;
        o_res.iterations = r_n;
        if (r_n == i_cfg.iteration_limit) begin
            o_res.band = jet_pkg::BAND_INSIDE;
        end else if (r_n < jet_pkg::BAND_LOW_LIM) begin
            o_res.band = jet_pkg::BAND_LOW;
        end else if (r_n < jet_pkg::BAND_MID_LIM) begin
            o_res.band = jet_pkg::BAND_MID;
        end else begin
            o_res.band = jet_pkg::BAND_HIGH;
        end
    end

endmodule

[rtl/julia_escape_time_pixel.sv]
// A pixel passes S_XMUL, S_XSUM and S_YSUM to form the start point, then iterates until
// it escapes or the iteration limit is reached, then waits in S_DONE for the output register.
// One pixel is in work at a time; each iteration takes three passes through the single
// 32x32 multiplier (S_TEST, S_IISQ, S_ESC) plus the update state S_UPD.
// The input side stalls from transfer until the result moves to the output register.
// Reset (synchronous, active low): sequencer idle, output empty, configuration defaults.
module julia_escape_time_pixel #(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  jet_pkg::t_pix_in                   i_pixel,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output jet_pkg::t_pix_out                  o_result,
    input  logic                               i_cfg_we,
    input  logic [jet_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [31:0]                        i_cfg_data
);

    jet_pkg::t_cfg     r_cfg;
    logic              r_out_valid;
    jet_pkg::t_pix_out r_result;

    logic              seq_idle, seq_done, out_free, load, start;
    jet_pkg::t_pix_out seq_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.c_re            <= '0;
            r_cfg.c_im            <= '0;
            r_cfg.iteration_limit <= 16'd100;
            r_cfg.origin_re       <= -32'sd536870912;
            r_cfg.origin_im       <= 32'sd536870912;
            r_cfg.step_re         <= 31'd1048576;
            r_cfg.step_im         <= 31'd1048576;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                jet_pkg::REG_C_RE:      r_cfg.c_re            <= i_cfg_data;
                jet_pkg::REG_C_IM:      r_cfg.c_im            <= i_cfg_data;
                jet_pkg::REG_ITER_LIM:  r_cfg.iteration_limit <= i_cfg_data[15:0];
                jet_pkg::REG_ORIGIN_RE: r_cfg.origin_re       <= i_cfg_data;
                jet_pkg::REG_ORIGIN_IM: r_cfg.origin_im       <= i_cfg_data;
                jet_pkg::REG_STEP_RE:   r_cfg.step_re         <= i_cfg_data[30:0];
                jet_pkg::REG_STEP_IM:   r_cfg.step_im         <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign start    = i_in_valid && seq_idle;
    assign out_free = !r_out_valid || !i_out_stall;
    assign load     = seq_done && out_free;

    jet_seq #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_start (start),
        .i_pix   (i_pixel),
        .i_take  (out_free),
        .o_idle  (seq_idle),
        .o_done  (seq_done),
        .o_res   (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= seq_res;
        end
    end

    assign o_in_stall  = !seq_idle;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // a transfer on the input starts work, so the next item must wait
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transfer");

    a_band_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_result.band == jet_pkg::BAND_INSIDE)
                         == (o_result.iterations == r_cfg.iteration_limit)))
        else $error("inside band does not match iteration limit");

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_result.iterations <= r_cfg.iteration_limit))
        else $error("iteration count above limit");

    a_x_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({3'd0, o_result.out_x} < 13'(FRAME_WIDTH)))
        else $error("column outside frame");

endmodule
